// File: src/hotp_pkg.sv
// ----------------------------------------------------------------------------
// hotp_pkg
// shared constants and types for the hotp code generator
// ----------------------------------------------------------------------------
package hotp_pkg;

  localparam int unsigned OtpModulus = 1000000;
  localparam int unsigned KeyWords   = 7;
  localparam int unsigned KeyMaxBytes = 56;
  localparam int unsigned KeyLenReset = 20;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [2:0] RegKeyLen = 3'd7;

  // one compression request to the shared round unit
  typedef struct packed {
    logic         start;
    logic [511:0] block;
    logic [159:0] chain;
  } sha_req_t;

  typedef struct packed {
    logic         done;
    logic [159:0] digest;
  } sha_rsp_t;

endpackage

// File: src/hotp_sha1_core.sv
// ----------------------------------------------------------------------------
// hotp_sha1_core
// sha-1 compression, one round per cycle over a 16-word schedule window
// ----------------------------------------------------------------------------
module hotp_sha1_core (
  input  logic              clk,
  input  logic              rst,
  input  hotp_pkg::sha_req_t req,
  output hotp_pkg::sha_rsp_t rsp
);

  logic [511:0] w;
  logic [31:0]  a, b, c, d, e;
  logic [159:0] chain;
  logic [6:0]   round;
  logic         busy;

  logic [31:0] f, k, t, wi, wn, x;

  always_comb begin
    wi = w[511:480];
    // window slots 13, 8, 2 and 0 give w[i+16]
    x  = w[95:64] ^ w[255:224] ^ w[447:416] ^ w[511:480];
    wn = {x[30:0], x[31]};
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = 32'h5A827999;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = 32'h6ED9EBA1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d;
      k = 32'hCA62C1D6;
    end
    t = {a[26:0], a[31:27]} + f + e + k + wi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      round    <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        round <= '0;
        w     <= req.block;
        chain <= req.chain;
        {a, b, c, d, e} <= req.chain;
      end else if (busy) begin
        w <= {w[479:0], wn};
        {a, b, c, d, e} <= {t, a, {b[1:0], b[31:2]}, c, d};
        if (round == 7'd79) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.digest <= {chain[159:128] + t, chain[127:96] + a,
                         chain[95:64] + {b[1:0], b[31:2]}, chain[63:32] + c,
                         chain[31:0] + d};
        end
        round <= round + 7'd1;
      end
    end
  end

endmodule

// File: src/hotp_mod_unit.sv
// ----------------------------------------------------------------------------
// hotp_mod_unit
// remainder by reciprocal multiply and one correcting subtract, four steps
// ----------------------------------------------------------------------------
module hotp_mod_unit #(
  parameter int unsigned OTP_MODULUS = hotp_pkg::OtpModulus
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] value,
  output logic        done,
  output logic [19:0] remainder
);

  localparam logic [31:0] Mod   = 32'(OTP_MODULUS);
  // floor(2^32 / modulus), quotient estimate is low by at most one
  localparam logic [12:0] Recip = 13'(64'h1_0000_0000 / 64'(OTP_MODULUS));

  logic [30:0] x;
  logic [43:0] prod;
  logic [43:0] qd;
  logic [31:0] diff;
  logic [3:0]  phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      done  <= phase[3];
      phase <= {phase[2:0], start && (phase == 4'd0)};
      if (start && (phase == 4'd0)) x <= value;
      if (phase[0]) prod <= 44'(x) * 44'(Recip);
      if (phase[1]) qd <= 44'(prod[43:32]) * 44'(Mod);
      if (phase[2]) diff <= {1'b0, x} - qd[31:0];
      if (phase[3]) remainder <= (diff >= Mod) ? 20'(diff - Mod) : diff[19:0];
    end
  end

endmodule

// File: src/hotp_code_generator_top.sv
// ----------------------------------------------------------------------------
// hotp_code_generator_top
// hotp one-time password generator, hmac-sha1 with six-digit truncation
// ----------------------------------------------------------------------------
// a word accepted goes through four sha-1 compressions (issue, 80 rounds,
// hand-over) through the single round unit, then truncation and the
// reciprocal remainder before the code is shown. one word at a time; the
// next word is taken only after the code is taken, so an output stall
// holds it. synchronous reset clears control and sets key_length to 20,
// key 0.
module hotp_code_generator_top #(
  parameter int unsigned OTP_MODULUS = hotp_pkg::OtpModulus
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] counter,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] otp_code
);

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_IN1   = 7'b0000010,
    S_IN2   = 7'b0000100,
    S_OUT1  = 7'b0001000,
    S_OUT2  = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_SHOW  = 7'b1000000
  } state_t;

  state_t state;
  logic [63:0] key_word [hotp_pkg::KeyWords];
  logic [5:0]  key_length;
  logic [63:0] cnt_reg;
  logic [159:0] hstate, inner;
  logic        issued;

  hotp_pkg::sha_req_t req;
  hotp_pkg::sha_rsp_t rsp;

  // apb register file, eight-byte spacing
  logic [2:0] ridx;
  assign ridx   = paddr[5:3];
  assign pready = 1'b1;

  always_comb begin
    if (ridx == hotp_pkg::RegKeyLen) prdata = {58'd0, key_length};
    else prdata = key_word[ridx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hotp_pkg::KeyWords; i++) key_word[i] <= '0;
      key_length <= 6'(hotp_pkg::KeyLenReset);
    end else if (psel && penable && pwrite) begin
      if (ridx == hotp_pkg::RegKeyLen) key_length <= pwdata[5:0];
      else key_word[ridx] <= pwdata;
    end
  end

  // masked, zero-padded key block
  logic [511:0] key_blk;
  logic [5:0]   klen;
  assign klen = (key_length > 6'(hotp_pkg::KeyMaxBytes)) ?
                6'(hotp_pkg::KeyMaxBytes) : key_length;

  always_comb begin
    key_blk = '0;
    for (int i = 0; i < 56; i++) begin
      if (6'(i) < klen)
        key_blk[511 - 8*i -: 8] = key_word[i/8][63 - 8*(i%8) -: 8];
    end
  end

  // block for the current step
  always_comb begin
    req.start = (state != S_IDLE) && (state != S_MOD) && (state != S_SHOW) && !issued;
    req.chain = hstate;
    case (state)
      S_IN1:   req.block = key_blk ^ {64{8'h36}};
      S_IN2:   req.block = {cnt_reg, 8'h80, 376'd0, 64'd576};
      S_OUT1:  req.block = key_blk ^ {64{8'h5C}};
      S_OUT2:  req.block = {inner, 8'h80, 280'd0, 64'd672};
      default: req.block = '0;
    endcase
  end

  hotp_sha1_core u_core (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // dynamic truncation of the final digest
  logic [3:0]  off;
  logic [30:0] bin;
  logic        mod_start, mod_done;
  logic [19:0] rem;
  logic [159:0] dig;
  logic [30:0] bin_reg;
  assign dig = rsp.digest;
  assign off = dig[3:0];
  always_comb begin
    logic [31:0] sel;
    sel = dig[159 - 8*off -: 32];
    bin = sel[30:0];
  end

  hotp_mod_unit #(.OTP_MODULUS(OTP_MODULUS)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .value(bin_reg),
    .done(mod_done), .remainder(rem)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_SHOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      mod_start <= 1'b0;
    end else begin
      mod_start <= 1'b0;
      if (req.start) issued <= 1'b1;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt_reg <= counter;
            hstate  <= {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2,
                        hotp_pkg::H3, hotp_pkg::H4};
            issued  <= 1'b0;
            state   <= S_IN1;
          end
        end
        S_IN1: if (rsp.done) begin
          hstate <= rsp.digest; issued <= 1'b0; state <= S_IN2;
        end
        S_IN2: if (rsp.done) begin
          inner  <= rsp.digest;
          hstate <= {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2,
                     hotp_pkg::H3, hotp_pkg::H4};
          issued <= 1'b0; state <= S_OUT1;
        end
        S_OUT1: if (rsp.done) begin
          hstate <= rsp.digest; issued <= 1'b0; state <= S_OUT2;
        end
        S_OUT2: if (rsp.done) begin
          bin_reg   <= bin;
          mod_start <= 1'b1;
          state     <= S_MOD;
        end
        S_MOD: if (mod_done) begin
          otp_code <= rem;
          state    <= S_SHOW;
        end
        S_SHOW: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/tb_hotp_code_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hotp_code_generator_top
// self-checking bench: hmac-sha1 hotp codes against an in-bench predictor
// ----------------------------------------------------------------------------
// counters go in through a queue-fed driver, codes are checked by a monitor
// in arrival order. the key and key length are rewritten between phases while
// the block is idle. both sides idle in random bursts except near the end.
module tb_hotp_code_generator_top;

  localparam int NumRandom = 1780;
  localparam int Watchdog  = 20000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] counter;
  logic        out_valid;
  logic        out_stall;
  logic [19:0] otp_code;

  hotp_code_generator_top i_dut (.*);

  // predictor copy of the registers
  logic [63:0] key_reg [hotp_pkg::KeyWords];
  logic [5:0]  key_len_reg;

  logic [63:0] counter_q [$];
  logic [19:0] code_q [$];
  int          errors;
  int          codes_seen;
  int          idle_cycles;
  bit          quiet;
  bit          timed_out;
  bit          in_acc;
  int          in_gap, out_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_block(logic [159:0] chain, logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    a = chain[159:128]; b = chain[127:96]; c = chain[95:64];
    d = chain[63:32]; e = chain[31:0];
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {chain[159:128] + a, chain[127:96] + b, chain[95:64] + c,
            chain[63:32] + d, chain[31:0] + e};
  endfunction

  // hmac over the counter, then dynamic truncation
  function automatic logic [19:0] hotp_code(logic [63:0] ctr);
    logic [511:0] key_blk, tail;
    logic [159:0] h, inner, dig;
    logic [7:0]   dbytes [20];
    logic [31:0]  bin;
    int           used, off;
    used = (key_len_reg > hotp_pkg::KeyMaxBytes) ? hotp_pkg::KeyMaxBytes : key_len_reg;
    key_blk = '0;
    for (int i = 0; i < used; i++)
      key_blk[511 - 8 * i -: 8] = key_reg[i / 8][63 - 8 * (i % 8) -: 8];
    h = sha1_block({hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3,
                    hotp_pkg::H4}, key_blk ^ {64{8'h36}});
    tail = {ctr, 8'h80, 376'b0, 64'd576};
    inner = sha1_block(h, tail);
    h = sha1_block({hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3,
                    hotp_pkg::H4}, key_blk ^ {64{8'h5C}});
    tail = {inner, 8'h80, 280'b0, 64'd672};
    dig = sha1_block(h, tail);
    for (int i = 0; i < 20; i++) dbytes[i] = dig[159 - 8 * i -: 8];
    off = dbytes[19] & 8'h0f;
    bin = {dbytes[off] & 8'h7f, dbytes[off+1], dbytes[off+2], dbytes[off+3]};
    return 20'((bin % hotp_pkg::OtpModulus));
  endfunction

  task automatic report_mismatch(string what, logic [19:0] got, logic [19:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: one word at a time from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      // current word accepted at the last edge, or nothing pending
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (counter_q.size() > 0) begin
        counter <= counter_q.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 7);
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk) begin
    in_acc = !rst && in_valid && !in_stall;
    if (!rst) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        code_q.push_back(hotp_code(counter));
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        codes_seen++;
        if (code_q.size() == 0) begin
          report_mismatch("unexpected word", otp_code, '0);
        end else if (otp_code !== code_q[0]) begin
          report_mismatch("otp_code", otp_code, code_q.pop_front());
        end else begin
          void'(code_q.pop_front());
        end
      end
      if (idle_cycles >= Watchdog) timed_out = 1'b1;
    end
  end

  task automatic reg_write(int idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 6'(8 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < hotp_pkg::KeyWords) key_reg[idx] = val;
    else if (idx == hotp_pkg::RegKeyLen) key_len_reg = val[5:0];
  endtask

  // wait until every queued word is out and the block has settled
  task automatic drain();
    while ((counter_q.size() > 0 || in_valid || code_q.size() > 0) && !timed_out)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_key(int len);
    for (int i = 0; i < hotp_pkg::KeyWords; i++) reg_write(i, {$urandom, $urandom});
    reg_write(hotp_pkg::RegKeyLen, 64'(len));
  endtask

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; counter = '0; out_stall = 0;
    errors = 0; codes_seen = 0; idle_cycles = 0; quiet = 0; timed_out = 0;
    in_gap = 0; out_gap = 0;
    for (int i = 0; i < hotp_pkg::KeyWords; i++) key_reg[i] = '0;
    key_len_reg = hotp_pkg::KeyLenReset;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset key (zero, length 20), counter extremes
    counter_q.push_back(64'd0);
    counter_q.push_back('1);
    counter_q.push_back(64'h8000_0000_0000_0000);
    counter_q.push_back(64'd1);
    drain();

    // rfc 4226 test key "12345678901234567890"
    reg_write(0, 64'h3132333435363738);
    reg_write(1, 64'h3930313233343536);
    reg_write(2, 64'h3738393000000000);
    for (int i = 3; i < hotp_pkg::KeyWords; i++) reg_write(i, '1);
    reg_write(hotp_pkg::RegKeyLen, 64'd20);
    for (int i = 0; i < 10; i++) counter_q.push_back(64'(i));
    drain();

    // length extremes: empty key, full key, saturating length
    random_key(0);
    counter_q.push_back('1);
    counter_q.push_back(64'h5555_aaaa_5555_aaaa);
    drain();
    random_key(56);
    counter_q.push_back(64'haaaa_5555_aaaa_5555);
    drain();
    reg_write(hotp_pkg::RegKeyLen, 64'd63);
    counter_q.push_back(64'd0);
    counter_q.push_back('1);
    drain();
    reg_write(hotp_pkg::RegKeyLen, 64'd57);
    counter_q.push_back(64'd42);
    drain();

    // random phases with varied keys
    for (int p = 0; p < 10 && !timed_out; p++) begin
      random_key((p % 3 == 0) ? $urandom_range(0, 63) : $urandom_range(1, 56));
      if (p == 9) quiet = 1'b1;
      for (int i = 0; i < NumRandom / 10; i++)
        counter_q.push_back({$urandom, $urandom});
      drain();
    end

    $display("covered %0d codes over key lengths 0 to 63 incl. saturation,", codes_seen);
    $display("counter extremes and random keys with idle and stall bursts");
    if (timed_out) begin
      $display("== FAIL ==");
    end else if (errors == 0 && code_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
src/hotp_pkg.sv
src/hotp_sha1_core.sv
src/hotp_mod_unit.sv
src/hotp_code_generator_top.sv
test/tb_hotp_code_generator_top.sv
